// ===== src/dmm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants of the dense matrix multiplier.
// ----------------------------------------------------------------------------
package dmm_pkg;

    localparam int IDX_W  = 3;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 39;

    localparam logic CMD_B = 1'b0;
    localparam logic CMD_A = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] a;
        logic [IDX_W-1:0]        k;
    } t_chain_beat;

    typedef struct packed {
        logic                    shift;
        logic                    wr_en;
        logic [IDX_W-1:0]        wr_k;
        logic [IDX_W-1:0]        wr_j;
        logic signed [VAL_W-1:0] wr_data;
    } t_cell_ctl;

endpackage

// ===== src/dmm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_in_if / dmm_out_if
// Valid-ready channels for element beats and result beats.
// ----------------------------------------------------------------------------
interface dmm_in_if;
    logic                                     valid;
    logic                                     ready;
    logic                                     cmd;
    logic [dmm_pkg::IDX_W-1:0]                index_k;
    logic [dmm_pkg::IDX_W-1:0]                index_j;
    logic signed [dmm_pkg::VAL_W-1:0]         value;

    modport source (output valid, output cmd, output index_k, output index_j,
                    output value, input ready);
    modport sink   (input valid, input cmd, input index_k, input index_j,
                    input value, output ready);
endinterface

interface dmm_out_if;
    logic                                     valid;
    logic                                     ready;
    logic [dmm_pkg::IDX_W-1:0]                row_index;
    logic [dmm_pkg::IDX_W-1:0]                col_index;
    logic signed [dmm_pkg::ACC_W-1:0]         sum;
    logic                                     last;

    modport source (output valid, output row_index, output col_index,
                    output sum, output last, input ready);
    modport sink   (input valid, input row_index, input col_index,
                    input sum, input last, output ready);
endinterface

// ===== src/dmm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_wr_en,
    input  logic [AW-1:0]           i_wr_addr,
    input  logic [WIDTH-1:0]        i_wr_data,
    input  logic [AW-1:0]           i_rd_addr,
    output logic [WIDTH-1:0]        o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/dmm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmm_cell
// One column of C: holds column COL of B and its accumulator, forwards the
// A element to the next cell and shifts sums toward the head on readout.
// ----------------------------------------------------------------------------
module dmm_cell #(
    parameter int DIM = 8,
    parameter int COL = 0
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  dmm_pkg::t_cell_ctl                    i_ctl,
    input  dmm_pkg::t_chain_beat                  i_beat,
    output dmm_pkg::t_chain_beat                  o_beat,
    input  logic signed [dmm_pkg::ACC_W-1:0]      i_acc_next,
    output logic signed [dmm_pkg::ACC_W-1:0]      o_acc
);
    localparam int AW = (DIM > 1) ? $clog2(DIM) : 1;

    dmm_pkg::t_chain_beat                 r_beat;
    logic                                 r_prod_vld;
    logic signed [dmm_pkg::PROD_W-1:0]    r_prod;
    logic signed [dmm_pkg::ACC_W-1:0]     r_acc;
    logic [dmm_pkg::VAL_W-1:0]            w_rd_data;
    logic [AW+dmm_pkg::IDX_W-1:0]         w_rd_x;
    logic [AW+dmm_pkg::IDX_W-1:0]         w_wr_x;
    logic                                 w_wr_en;

    assign w_rd_x  = {{AW{1'b0}}, i_beat.k};
    assign w_wr_x  = {{AW{1'b0}}, i_ctl.wr_k};
    assign w_wr_en = i_ctl.wr_en && (32'(i_ctl.wr_j) == COL);

    dmm_ram #(
        .WIDTH (dmm_pkg::VAL_W),
        .DEPTH (DIM)
    ) u_bcol (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_x[AW-1:0]),
        .i_wr_data (i_ctl.wr_data),
        .i_rd_addr (w_rd_x[AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        r_beat.a <= i_beat.a;
        r_beat.k <= i_beat.k;
        r_prod   <= r_beat.a * $signed(w_rd_data);
        if (!i_rst_n) begin
            r_beat.vld <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_beat.vld <= i_beat.vld;
            r_prod_vld <= r_beat.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.shift) begin
            r_acc <= i_acc_next;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + dmm_pkg::ACC_W'(r_prod);
        end
    end

    assign o_beat = r_beat;
    assign o_acc  = r_acc;

endmodule

// ===== src/dense_matrix_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// Row-at-a-time C = A x B over a chain of DIM column cells.
//
//   Port    Dir  Handshake     Beat contents
//   i_in    in   valid/ready   cmd, index_k, index_j, value
//   o_res   out  valid/ready   row_index, col_index, sum, last
//
// A B beat is written to one cell's B column RAM while the chain stays idle.
// An A beat walks the chain one cell per cycle; each cell reads its B column
// RAM, multiplies and accumulates. A beat that closes a row then drains DIM
// result beats, one per cycle when o_res allows, shifting sums to the head.
// Reset is synchronous and clears control and accumulators; B RAM is not
// cleared. o_res.ready low stalls the drain; i_in.ready is high only when idle.
// ----------------------------------------------------------------------------
module dense_matrix_multiply #(
    parameter int DIM = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dmm_in_if.sink            i_in,
    dmm_out_if.source         o_res
);
    localparam int AW   = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int CNTW = $clog2(DIM + 1);
    localparam logic [AW-1:0]   COL_LAST = AW'(DIM - 1);
    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DIM);

    dmm_pkg::t_state                      r_state;
    dmm_pkg::t_state                      n_state;
    logic [CNTW-1:0]                      r_cnt;
    logic [AW-1:0]                        r_col;
    logic [AW-1:0]                        r_row;
    logic                                 r_close;
    logic                                 r_out_valid;
    logic [AW-1:0]                        r_out_row;
    logic [AW-1:0]                        r_out_col;
    logic signed [dmm_pkg::ACC_W-1:0]     r_out_sum;
    logic                                 r_out_last;

    logic                                 w_in_fire;
    logic                                 w_k_ok;
    logic                                 w_a_fire;
    logic                                 w_drain_fire;
    logic                                 w_in_ready;
    dmm_pkg::t_cell_ctl                   w_ctl;
    dmm_pkg::t_chain_beat                 w_beat [DIM+1];
    logic signed [dmm_pkg::ACC_W-1:0]     w_acc  [DIM+1];
    logic [AW+dmm_pkg::IDX_W-1:0]         w_row_x;
    logic [AW+dmm_pkg::IDX_W-1:0]         w_col_x;

    assign w_in_fire    = i_in.valid && i_in.ready;
    assign w_k_ok       = 32'(i_in.index_k) < DIM;
    assign w_a_fire     = w_in_fire && (i_in.cmd == dmm_pkg::CMD_A) && w_k_ok;
    assign w_drain_fire = (r_state == dmm_pkg::ST_DRAIN) && (!r_out_valid || o_res.ready);

    assign w_ctl.shift   = w_drain_fire;
    assign w_ctl.wr_en   = w_in_fire && (i_in.cmd == dmm_pkg::CMD_B) && w_k_ok;
    assign w_ctl.wr_k    = i_in.index_k;
    assign w_ctl.wr_j    = i_in.index_j;
    assign w_ctl.wr_data = i_in.value;

    assign w_beat[0].vld = w_a_fire;
    assign w_beat[0].a   = i_in.value;
    assign w_beat[0].k   = i_in.index_k;
    assign w_acc[DIM]    = '0;

    for (genvar c = 0; c < DIM; c++) begin : g_cell
        dmm_cell #(
            .DIM (DIM),
            .COL (c)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_beat     (w_beat[c]),
            .o_beat     (w_beat[c+1]),
            .i_acc_next (w_acc[c+1]),
            .o_acc      (w_acc[c])
        );
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmm_pkg::ST_IDLE: begin
                if (w_a_fire) begin
                    n_state = dmm_pkg::ST_RUN;
                end
            end
            dmm_pkg::ST_RUN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = r_close ? dmm_pkg::ST_DRAIN : dmm_pkg::ST_IDLE;
                end
            end
            dmm_pkg::ST_DRAIN: begin
                if (w_drain_fire && (r_col == COL_LAST)) begin
                    n_state = dmm_pkg::ST_IDLE;
                end
            end
            default: n_state = dmm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        unique case (r_state)
            dmm_pkg::ST_IDLE:  w_in_ready = 1'b1;
            dmm_pkg::ST_RUN:   w_in_ready = 1'b0;
            dmm_pkg::ST_DRAIN: w_in_ready = 1'b0;
            default:           w_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmm_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_close     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == dmm_pkg::ST_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (w_a_fire) begin
                r_close <= (32'(i_in.index_k) == DIM - 1);
            end
            if (w_drain_fire) begin
                r_col <= (r_col == COL_LAST) ? '0 : r_col + 1'b1;
                if (r_col == COL_LAST) begin
                    r_row <= (r_row == COL_LAST) ? '0 : r_row + 1'b1;
                end
            end
            if (w_drain_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_drain_fire) begin
            r_out_row  <= r_row;
            r_out_col  <= r_col;
            r_out_sum  <= w_acc[0];
            r_out_last <= (r_col == COL_LAST);
        end
    end

    assign w_row_x = {{dmm_pkg::IDX_W{1'b0}}, r_out_row};
    assign w_col_x = {{dmm_pkg::IDX_W{1'b0}}, r_out_col};

    assign i_in.ready      = w_in_ready;
    assign o_res.valid     = r_out_valid;
    assign o_res.row_index = w_row_x[dmm_pkg::IDX_W-1:0];
    assign o_res.col_index = w_col_x[dmm_pkg::IDX_W-1:0];
    assign o_res.sum       = r_out_sum;
    assign o_res.last      = r_out_last;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != dmm_pkg::ST_IDLE) |-> !w_in_fire)
        else $error("Beat accepted while the chain is busy.");

    a_drain_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_drain_fire && (r_col == COL_LAST)) |=> (r_state == dmm_pkg::ST_IDLE))
        else $error("Drain did not return to idle after the last column.");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_drain_fire && (r_col == COL_LAST)) |=> (w_acc[0] == '0))
        else $error("Accumulators not cleared after a row was drained.");

    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (r_out_col == COL_LAST))
        else $error("Last flag on a column other than the final one.");

    a_drain_needs_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dmm_pkg::ST_RUN) && (n_state == dmm_pkg::ST_DRAIN)) |-> r_close)
        else $error("Drain started for a beat that does not close the row.");

endmodule

// ===== sim/tb_dense_matrix_multiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dense_matrix_multiply
// Self-checking bench for the row-at-a-time matrix multiplier. A scoreboard
// keeps its own copy of B, the row accumulators and the row counter, predicts
// every C row that an accepted A beat closes, and compares each result beat
// field by field. Stimulus opens with a directed part on value extremes,
// duplicate and missing A columns, then fills B and runs random A rows and
// B rewrites under four handshake phases, with one long output hold-off and
// a full drain between phases. Every B element is written before it is read.
// ----------------------------------------------------------------------------
module tb_dense_matrix_multiply;

    localparam int DIM          = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_BEATS  = 72;

    typedef struct {
        logic [dmm_pkg::IDX_W-1:0]        row;
        logic [dmm_pkg::IDX_W-1:0]        col;
        logic signed [dmm_pkg::ACC_W-1:0] sum;
        logic                             last;
    } t_c_entry;

    class matmul_scoreboard;
        logic signed [dmm_pkg::VAL_W-1:0] b_mat [DIM][DIM];
        logic signed [dmm_pkg::ACC_W-1:0] row_acc [DIM];
        logic [dmm_pkg::IDX_W-1:0]        row_cnt;
        t_c_entry                         c_rows_q [$];
        int                               mismatches;
        int                               results_seen;
        int                               rows_closed;

        function new();
            row_cnt      = '0;
            mismatches   = 0;
            results_seen = 0;
            rows_closed  = 0;
            foreach (row_acc[c]) row_acc[c] = '0;
        endfunction

        function int pending();
            return c_rows_q.size();
        endfunction

        function void note_beat(logic cmd, logic [dmm_pkg::IDX_W-1:0] k,
                                logic [dmm_pkg::IDX_W-1:0] j,
                                logic signed [dmm_pkg::VAL_W-1:0] value);
            logic signed [dmm_pkg::PROD_W-1:0] prod;
            t_c_entry                          entry;
            if (cmd == dmm_pkg::CMD_B) begin
                b_mat[k][j] = value;
            end else begin
                for (int c = 0; c < DIM; c++) begin
                    prod       = value * b_mat[k][c];
                    row_acc[c] = row_acc[c] + prod;
                end
                if (k == DIM - 1) begin
                    for (int c = 0; c < DIM; c++) begin
                        entry.row  = row_cnt;
                        entry.col  = dmm_pkg::IDX_W'(c);
                        entry.sum  = row_acc[c];
                        entry.last = (c == DIM - 1);
                        c_rows_q.push_back(entry);
                        row_acc[c] = '0;
                    end
                    row_cnt = (row_cnt == DIM - 1) ? '0 : row_cnt + 1'b1;
                    rows_closed++;
                end
            end
        endfunction

        function void check_result(logic [dmm_pkg::IDX_W-1:0] row,
                                   logic [dmm_pkg::IDX_W-1:0] col,
                                   logic signed [dmm_pkg::ACC_W-1:0] sum, logic last);
            t_c_entry exp_c;
            results_seen++;
            if (c_rows_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat row %0d col %0d sum %0d last %0b",
                         $time, row, col, sum, last);
            end else begin
                exp_c = c_rows_q.pop_front();
                if (row !== exp_c.row || col !== exp_c.col || sum !== exp_c.sum
                        || last !== exp_c.last) begin
                    mismatches++;
                    $display("%0t: result mismatch expected row %0d col %0d sum %0d last %0b",
                             $time, exp_c.row, exp_c.col, exp_c.sum, exp_c.last);
                    $display("%0t:                 actual   row %0d col %0d sum %0d last %0b",
                             $time, row, col, sum, last);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    dmm_in_if  in_ch ();
    dmm_out_if res_ch ();

    dense_matrix_multiply #(
        .DIM (DIM)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    matmul_scoreboard sb = new();

    int send_idle_pct;
    int recv_stall_pct;
    int hold_seq;
    int hold_seen;
    int hold_left;
    int beats_sent;
    int cycle_cnt;

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("FAIL dense_matrix_multiply");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_result(res_ch.row_index, res_ch.col_index, res_ch.sum, res_ch.last);
        end
    end

    function automatic logic signed [dmm_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return dmm_pkg::VAL_W'($urandom);
        endcase
    endfunction

    task automatic send_beat(input logic cmd, input logic [dmm_pkg::IDX_W-1:0] k,
                             input logic [dmm_pkg::IDX_W-1:0] j,
                             input logic signed [dmm_pkg::VAL_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.index_k <= k;
        in_ch.index_j <= j;
        in_ch.value   <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note_beat(cmd, k, j, value);
        beats_sent++;
    endtask

    task automatic send_b_random();
        send_beat(dmm_pkg::CMD_B, dmm_pkg::IDX_W'($urandom_range(0, DIM - 1)),
                  dmm_pkg::IDX_W'($urandom_range(0, DIM - 1)), pick_value());
    endtask

    task automatic send_a_row();
        int r;
        for (int k = 0; k < DIM; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10) send_b_random();
            if (k == DIM - 1 || r >= 18) begin
                send_beat(dmm_pkg::CMD_A, dmm_pkg::IDX_W'(k),
                          dmm_pkg::IDX_W'($urandom_range(0, DIM - 1)), pick_value());
                if (k != DIM - 1 && r >= 92) begin
                    send_beat(dmm_pkg::CMD_A, dmm_pkg::IDX_W'(k),
                              dmm_pkg::IDX_W'($urandom_range(0, DIM - 1)), pick_value());
                end
            end
        end
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int goal;
        int r;
        goal           = beats_sent + PHASE_BEATS;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (beats_sent < goal) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
                send_a_row();
            end else if (r < 82) begin
                repeat ($urandom_range(1, 4)) send_b_random();
            end else begin
                send_beat(dmm_pkg::CMD_A, dmm_pkg::IDX_W'($urandom_range(0, DIM - 1)),
                          dmm_pkg::IDX_W'($urandom_range(0, DIM - 1)), pick_value());
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.cmd      = dmm_pkg::CMD_B;
        in_ch.index_k  = '0;
        in_ch.index_j  = '0;
        in_ch.value    = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        beats_sent     = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(dmm_pkg::CMD_B, 3'd7, 3'd0, 16'sh8000);
        send_beat(dmm_pkg::CMD_B, 3'd7, 3'd1, 16'sh7fff);
        send_beat(dmm_pkg::CMD_B, 3'd7, 3'd2, -16'sd1);
        send_beat(dmm_pkg::CMD_B, 3'd7, 3'd3, 16'sh0000);
        send_beat(dmm_pkg::CMD_B, 3'd7, 3'd4, 16'sd1);
        send_beat(dmm_pkg::CMD_B, 3'd7, 3'd5, 16'sh8000);
        send_beat(dmm_pkg::CMD_B, 3'd7, 3'd6, 16'sh7fff);
        send_beat(dmm_pkg::CMD_B, 3'd7, 3'd7, 16'sh5555);
        send_beat(dmm_pkg::CMD_A, 3'd7, 3'd0, 16'sh8000);
        send_beat(dmm_pkg::CMD_A, 3'd7, 3'd7, 16'sh7fff);
        for (int j = 0; j < DIM; j++) begin
            send_beat(dmm_pkg::CMD_B, 3'd0, dmm_pkg::IDX_W'(j), 16'sh8000);
        end
        send_beat(dmm_pkg::CMD_A, 3'd0, 3'd7, 16'sh8000);
        send_beat(dmm_pkg::CMD_A, 3'd0, 3'd0, 16'sh8000);
        send_beat(dmm_pkg::CMD_A, 3'd7, 3'd3, 16'sh7fff);
        send_beat(dmm_pkg::CMD_A, 3'd7, 3'd5, 16'sh0000);
        drain_results();

        for (int k = 0; k < DIM; k++) begin
            for (int j = 0; j < DIM; j++) begin
                send_beat(dmm_pkg::CMD_B, dmm_pkg::IDX_W'(k), dmm_pkg::IDX_W'(j),
                          pick_value());
            end
        end

        hold_seq <= hold_seq + 1;
        repeat (3) send_a_row();
        drain_results();

        run_phase(0, 0);
        run_phase(50, 0);
        run_phase(0, 50);
        run_phase(27, 27);

        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4 * DIM + 8) @(posedge i_clk);

        $display("Run covered %0d input beats and %0d result beats over %0d C rows,",
                 beats_sent, sb.results_seen, sb.rows_closed);
        $display("with idle and stall phases, a long output hold-off and %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS dense_matrix_multiply");
        end else begin
            $display("FAIL dense_matrix_multiply");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/dmm_pkg.sv
src/dmm_if.sv
src/dmm_ram.sv
src/dmm_cell.sv
src/dense_matrix_multiply.sv
sim/tb_dense_matrix_multiply.sv
